// ----- rtl/dta_pkg.sv -----
// shared constants, types and arctangent table for the direction-to-angles unit
// no dependencies; imported by the stage, skid and top-level modules
`default_nettype none

package dta_pkg;

	// default field widths
	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF     = 16;

	// fixed-point formats of the datapath
	localparam int GUARD  = 24;
	localparam int ITERS  = 30;
	localparam int ZSHIFT = 30 - GUARD;

	// cordic gain in q30
	localparam logic [31:0] GAIN_Q30 = 32'd1768195363;

	// turns in 2^32 units per full turn
	localparam logic [31:0] QUARTER_TURN32       = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN32          = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN32 = 32'hC000_0000;

	// atan(2^-i) in 2^32 units per turn
	localparam logic [31:0] ATAN_TAB [ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
		32'd20,        32'd10,        32'd5,         32'd3,        32'd1
	};

	// per-vector flags carried alongside the datapath
	typedef struct packed {
		logic zero_h;  // x and y both zero
		logic x_zero;  // vector on the y axis
		logic y_pos;   // y greater than zero
		logic z_pos;   // z greater than zero
	} dta_flags_t;

	localparam int FLAGS_W = $bits(dta_flags_t);

endpackage

`default_nettype wire

// ----- rtl/dta_vec_if.sv -----
// valid/ready channel carrying one direction vector per transaction
// no dependencies
`default_nettype none

interface dta_vec_if #(
	parameter int COMPONENT_WIDTH = 16
);
	logic                              valid;
	logic                              ready;
	logic signed [COMPONENT_WIDTH-1:0] dir_x;
	logic signed [COMPONENT_WIDTH-1:0] dir_y;
	logic signed [COMPONENT_WIDTH-1:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/dta_ang_if.sv -----
// valid/ready channel carrying one yaw/pitch result per transaction
// no dependencies
`default_nettype none

interface dta_ang_if #(
	parameter int ANGLE_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH:0]   pitch_angle;
	logic        [ANGLE_WIDTH-1:0] yaw_angle;

	modport source (output valid, output pitch_angle, output yaw_angle, input ready);
	modport sink   (input valid, input pitch_angle, input yaw_angle, output ready);
endinterface

`default_nettype wire

// ----- rtl/dta_cordic_stage.sv -----
// one registered vectoring cordic iteration with side payload
// depends on dta_pkg
`default_nettype none

module dta_cordic_stage
	import dta_pkg::*;
#(
	parameter int          DW    = 44,
	parameter int          SW    = 8,
	parameter int          SHIFT = 0,
	parameter logic [31:0] ATAN  = 32'd0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [DW-1:0] in_x,
	input  wire logic signed [DW-1:0] in_y,
	input  wire logic        [31:0]   in_acc,
	input  wire logic        [SW-1:0] in_side,
	output logic                      out_valid,
	output logic signed [DW-1:0]      out_x,
	output logic signed [DW-1:0]      out_y,
	output logic        [31:0]        out_acc,
	output logic        [SW-1:0]      out_side
);

	logic signed [DW-1:0] dx, dy;
	logic signed [DW-1:0] nx, ny;
	logic        [31:0]   nacc;
	logic                 y_pos;
	logic                 valid_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	logic        [31:0]   acc_s1;
	logic        [SW-1:0] side_s1;

	// rotate towards the x axis, direction from the sign of y
	always_comb begin
		dx    = in_y >>> SHIFT;
		dy    = in_x >>> SHIFT;
		y_pos = !in_y[DW-1] && (|in_y);
		if (y_pos) begin
			nx   = in_x + dx;
			ny   = in_y - dy;
			nacc = in_acc + ATAN;
		end else begin
			nx   = in_x - dx;
			ny   = in_y + dy;
			nacc = in_acc - ATAN;
		end
	end

	// stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= nx;
			y_s1    <= ny;
			acc_s1  <= nacc;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_acc   = acc_s1;
	assign out_side  = side_s1;

endmodule

`default_nettype wire

// ----- rtl/dta_out_skid.sv -----
// output skid register between the pipeline and the result channel
// depends on dta_pkg and dta_ang_if
`default_nettype none

module dta_out_skid
	import dta_pkg::*;
#(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic signed [ANGLE_WIDTH:0]   in_pitch,
	input  wire logic        [ANGLE_WIDTH-1:0] in_yaw,
	output logic                               advance,
	dta_ang_if.source                          angles
);

	logic                          skid_v_q;
	logic signed [ANGLE_WIDTH:0]   skid_pitch_q;
	logic        [ANGLE_WIDTH-1:0] skid_yaw_q;

	// pipeline moves only while the skid slot is free
	assign advance = !skid_v_q;

	// slot fills when a result is stalled, empties once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			skid_v_q <= in_valid && !angles.ready;
		end else if (angles.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	// capture the stalled result
	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_pitch_q <= in_pitch;
			skid_yaw_q   <= in_yaw;
		end
	end

	// skid slot has priority on the channel
	assign angles.valid       = skid_v_q || in_valid;
	assign angles.pitch_angle = skid_v_q ? skid_pitch_q : in_pitch;
	assign angles.yaw_angle   = skid_v_q ? skid_yaw_q : in_yaw;

endmodule

`default_nettype wire

// ----- rtl/direction_to_angles_unit.sv -----
// Direction vector to yaw / negated pitch converter. Each vector transaction gives one
// result transaction through one input register that prepares the half-turn fold, ITERS
// yaw cordic stages, ITERS pitch cordic stages and one output register that handles the
// axis cases and rounds to ANGLE_WIDTH bits. Every cordic stage does a single iteration,
// so one vector per clock is sustained while the output skid slot is free. That slot
// holds one result while the sink stalls; vec.ready is registered and drops only while
// that slot is occupied. Angles use 2^ANGLE_WIDTH units per turn; reset clears only the
// valid bits, not the payload registers.
// depends on dta_pkg, dta_vec_if, dta_ang_if, dta_cordic_stage and dta_out_skid
`default_nettype none

module direction_to_angles_unit
	import dta_pkg::*;
#(
	parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
	parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dta_vec_if.sink   vec,
	dta_ang_if.source angles
);

	localparam int DW  = COMPONENT_WIDTH + GUARD + 4;
	localparam int PW  = COMPONENT_WIDTH + 32;
	localparam int YSW = DW + FLAGS_W;
	localparam int PSW = 32 + FLAGS_W;
	localparam int EXT = DW - COMPONENT_WIDTH - GUARD;

	logic en;

	// stage numbering: s1 input prep, cordic chains, s4 output

	// input prep: scale, fold negative x by a half turn, derive flags
	logic signed [DW-1:0] hx_in, hy_in;
	dta_flags_t           flags_in;
	logic                 x_neg;

	always_comb begin
		hx_in = {{EXT{vec.dir_x[COMPONENT_WIDTH-1]}}, vec.dir_x, {GUARD{1'b0}}};
		hy_in = {{EXT{vec.dir_y[COMPONENT_WIDTH-1]}}, vec.dir_y, {GUARD{1'b0}}};
		x_neg = vec.dir_x[COMPONENT_WIDTH-1];
		flags_in.x_zero = !(|vec.dir_x);
		flags_in.zero_h = !(|vec.dir_x) && !(|vec.dir_y);
		flags_in.y_pos  = !vec.dir_y[COMPONENT_WIDTH-1] && (|vec.dir_y);
		flags_in.z_pos  = !vec.dir_z[COMPONENT_WIDTH-1] && (|vec.dir_z);
	end

	logic                              valid_s1;
	logic signed [DW-1:0]              hx_s1, hy_s1;
	logic        [31:0]                base_s1;
	logic signed [COMPONENT_WIDTH-1:0] z_s1;
	dta_flags_t                        flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1    <= x_neg ? -hx_in : hx_in;
			hy_s1    <= x_neg ? -hy_in : hy_in;
			base_s1  <= x_neg ? HALF_TURN32 : 32'd0;
			z_s1     <= vec.dir_z;
			flags_s1 <= flags_in;
		end
	end

	assign vec.ready = en;

	// z scaled by the cordic gain, alongside the first yaw iteration
	logic signed [PW-1:0] z_prod, z_shift;
	logic signed [DW-1:0] zs;

	always_comb begin
		z_prod  = PW'($signed(z_s1)) * $signed({{(PW-32){1'b0}}, GAIN_Q30});
		z_shift = z_prod >>> ZSHIFT;
		zs      = z_shift[DW-1:0];
	end

	// yaw cordic chain, accumulator starts at the fold base
	logic                 yaw_v    [ITERS+1];
	logic signed [DW-1:0] yaw_x    [ITERS+1];
	logic signed [DW-1:0] yaw_y    [ITERS+1];
	logic        [31:0]   yaw_acc  [ITERS+1];
	logic        [YSW-1:0] yaw_side [ITERS+1];

	assign yaw_v[0]    = valid_s1;
	assign yaw_x[0]    = hx_s1;
	assign yaw_y[0]    = hy_s1;
	assign yaw_acc[0]  = base_s1;
	assign yaw_side[0] = {zs, flags_s1};

	for (genvar i = 0; i < ITERS; i++) begin : g_yaw
		dta_cordic_stage #(
			.DW    (DW),
			.SW    (YSW),
			.SHIFT (i),
			.ATAN  (ATAN_TAB[i])
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (yaw_v[i]),
			.in_x      (yaw_x[i]),
			.in_y      (yaw_y[i]),
			.in_acc    (yaw_acc[i]),
			.in_side   (yaw_side[i]),
			.out_valid (yaw_v[i+1]),
			.out_x     (yaw_x[i+1]),
			.out_y     (yaw_y[i+1]),
			.out_acc   (yaw_acc[i+1]),
			.out_side  (yaw_side[i+1])
		);
	end

	// pitch cordic chain on (horizontal magnitude, scaled z)
	logic                  pit_v    [ITERS+1];
	logic signed [DW-1:0]  pit_x    [ITERS+1];
	logic signed [DW-1:0]  pit_y    [ITERS+1];
	logic        [31:0]    pit_acc  [ITERS+1];
	logic        [PSW-1:0] pit_side [ITERS+1];

	assign pit_v[0]    = yaw_v[ITERS];
	assign pit_x[0]    = yaw_x[ITERS];
	assign pit_y[0]    = yaw_side[ITERS][YSW-1:FLAGS_W];
	assign pit_acc[0]  = 32'd0;
	assign pit_side[0] = {yaw_acc[ITERS], yaw_side[ITERS][FLAGS_W-1:0]};

	for (genvar i = 0; i < ITERS; i++) begin : g_pitch
		dta_cordic_stage #(
			.DW    (DW),
			.SW    (PSW),
			.SHIFT (i),
			.ATAN  (ATAN_TAB[i])
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (pit_v[i]),
			.in_x      (pit_x[i]),
			.in_y      (pit_y[i]),
			.in_acc    (pit_acc[i]),
			.in_side   (pit_side[i]),
			.out_valid (pit_v[i+1]),
			.out_x     (pit_x[i+1]),
			.out_y     (pit_y[i+1]),
			.out_acc   (pit_acc[i+1]),
			.out_side  (pit_side[i+1])
		);
	end

	// axis cases, rounding to ANGLE_WIDTH bits and pitch negation
	dta_flags_t                   fl;
	logic [31:0]                  yaw32, pitch32, yaw_sum, pitch_sum;
	logic [ANGLE_WIDTH-1:0]       yaw_r, pitch_r;
	logic signed [ANGLE_WIDTH:0]  pitch_neg;

	always_comb begin
		fl = dta_flags_t'(pit_side[ITERS][FLAGS_W-1:0]);
		priority if (fl.zero_h) begin
			yaw32   = 32'd0;
			pitch32 = fl.z_pos ? QUARTER_TURN32 : THREE_QUARTER_TURN32;
		end else if (fl.x_zero) begin
			yaw32   = fl.y_pos ? QUARTER_TURN32 : THREE_QUARTER_TURN32;
			pitch32 = pit_acc[ITERS];
		end else begin
			yaw32   = pit_side[ITERS][PSW-1:FLAGS_W];
			pitch32 = pit_acc[ITERS];
		end
		yaw_sum   = yaw32 + (32'd1 << (31 - ANGLE_WIDTH));
		pitch_sum = pitch32 + (32'd1 << (31 - ANGLE_WIDTH));
		yaw_r     = yaw_sum[31 -: ANGLE_WIDTH];
		pitch_r   = pitch_sum[31 -: ANGLE_WIDTH];
		pitch_neg = (ANGLE_WIDTH+1)'(0) - {1'b0, pitch_r};
	end

	logic                          valid_s4;
	logic signed [ANGLE_WIDTH:0]   pitch_s4;
	logic        [ANGLE_WIDTH-1:0] yaw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= pit_v[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_s4 <= pitch_neg;
			yaw_s4   <= yaw_r;
		end
	end

	// output skid slot
	dta_out_skid #(
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s4),
		.in_pitch (pitch_s4),
		.in_yaw   (yaw_s4),
		.advance  (en),
		.angles   (angles)
	);

	// a stalled final result moves into the skid slot and halts the pipeline
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && en && !angles.ready |=> !en && angles.valid)
		else $error("stalled result not captured by skid slot");

	// while the slot waits, the pipeline and the shown result hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && !angles.ready |=> !en && $stable(valid_s4) && $stable(pitch_s4)
			&& $stable(angles.pitch_angle) && $stable(angles.yaw_angle))
		else $error("pipeline moved while skid slot occupied");

	// a taken slot frees the pipeline in the next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!en && angles.ready |=> en)
		else $error("skid slot not released after transaction");

endmodule

`default_nettype wire

// ----- tb/sv/direction_to_angles_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench for direction_to_angles_unit: vectors in, yaw and negated pitch out,
// each result checked against a cordic predictor; depends on dta_pkg, dta_vec_if, dta_ang_if

module direction_to_angles_unit_tb;
	import dta_pkg::*;

	localparam int CW = COMPONENT_WIDTH_DEF;
	localparam int AW = ANGLE_WIDTH_DEF;
	// final wait: covers the pipeline stages plus a little margin for the skid slot
	localparam int LATENCY = 2 * ITERS + 8;

	typedef struct {
		logic signed [AW:0]   pitch;
		logic        [AW-1:0] yaw;
	} angle_pair_t;

	logic clk;
	logic arst_n;

	dta_vec_if #(.COMPONENT_WIDTH(CW)) vec ();
	dta_ang_if #(.ANGLE_WIDTH(AW))     angles ();

	direction_to_angles_unit #(
		.COMPONENT_WIDTH(CW),
		.ANGLE_WIDTH(AW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.vec(vec),
		.angles(angles)
	);

	angle_pair_t pending_angles[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// vectoring cordic: drives tgt towards zero, returns the angle in 2^32 units per turn
	function automatic bit [31:0] cordic_vector(inout longint mag, input longint tgt);
		bit [31:0] acc;
		longint cx, cy, dx, dy;
		int i;
		acc = '0;
		cx = mag;
		cy = tgt;
		for (i = 0; i < ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx = cx + dx;
				cy = cy - dy;
				acc = acc + ATAN_TAB[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				acc = acc - ATAN_TAB[i];
			end
		end
		mag = cx;
		return acc;
	endfunction

	// round a 32-bit angle to AW bits, wrapping a full turn to zero
	function automatic logic [AW-1:0] round_angle(input bit [31:0] a32);
		bit [31:0] t;
		t = a32 + (32'd1 << (31 - AW));
		return AW'(t >> (32 - AW));
	endfunction

	// expected yaw and negated pitch of one vector
	function automatic angle_pair_t predict_angles(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
		angle_pair_t res;
		longint hx, hy, zs;
		bit [31:0] yaw32, pitch32, base;
		logic [AW-1:0] pitch_rounded;
		if (x == 0 && y == 0) begin
			// zero horizontal vector: straight up, or straight down also for z of zero
			yaw32 = '0;
			pitch32 = (z > 0) ? QUARTER_TURN32 : THREE_QUARTER_TURN32;
		end else begin
			hx = longint'(x) <<< GUARD;
			hy = longint'(y) <<< GUARD;
			base = '0;
			// negative x: turn by half a turn first
			if (hx < 0) begin
				hx = -hx;
				hy = -hy;
				base = HALF_TURN32;
			end
			yaw32 = base + cordic_vector(hx, hy);
			// on the y axis the yaw is exact
			if (x == 0)
				yaw32 = (y > 0) ? QUARTER_TURN32 : THREE_QUARTER_TURN32;
			zs = (longint'(z) * longint'(GAIN_Q30)) >>> ZSHIFT;
			pitch32 = cordic_vector(hx, zs);
		end
		res.yaw = round_angle(yaw32);
		pitch_rounded = round_angle(pitch32);
		res.pitch = (AW + 1)'(0) - {1'b0, pitch_rounded};
		return res;
	endfunction

	// receiver: random stalls, or a long hold-off while hold_left counts down
	always @(posedge clk) begin
		if (hold_left > 0) begin
			angles.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			angles.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker: each result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		angle_pair_t want;
		if (arst_n && angles.valid && angles.ready) begin
			if (pending_angles.size() == 0) begin
				$display("%0t unexpected result: pitch_angle %0d yaw_angle %0d", $time,
					angles.pitch_angle, angles.yaw_angle);
				mismatch_count++;
			end else begin
				want = pending_angles.pop_front();
				if (angles.pitch_angle !== want.pitch) begin
					$display("%0t pitch_angle expected %0d actual %0d", $time,
						want.pitch, angles.pitch_angle);
					mismatch_count++;
				end
				if (angles.yaw_angle !== want.yaw) begin
					$display("%0t yaw_angle expected %0d actual %0d", $time,
						want.yaw, angles.yaw_angle);
					mismatch_count++;
				end
			end
		end
	end

	// offer one vector, with random idle cycles ahead of it, until it is accepted
	task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid <= 1'b1;
		vec.dir_x <= x;
		vec.dir_y <= y;
		vec.dir_z <= z;
		do
			@(posedge clk);
		while (!vec.ready);
		pending_angles.push_back(predict_angles(x, y, z));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_results_drained();
		vec.valid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0)
			@(posedge clk);
	endtask

	// one component by kind: full-range random, small (-16 to 16), a corner of the range, or zero
	function automatic logic signed [CW-1:0] pick_component(input int kind);
		logic signed [CW-1:0] corners [5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
		case (kind)
			0: begin
				return CW'($urandom);
			end
			1: begin
				return CW'($signed($urandom_range(32)) - 16);
			end
			2: begin
				return corners[$urandom_range(4)];
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	// axes, extremes, rounding near a full turn and the half-turn fold
	task automatic test_directed();
		logic signed [CW-1:0] dx [20] = '{0, 0, 0, 0, 0, 0, 0, 32767, -32768, -32768,
			32767, -1, 1, 32767, -32768, 1, 1, -1, 12345, -32768};
		logic signed [CW-1:0] dy [20] = '{0, 0, 0, 0, 100, -32768, 32767, 0, 0, -32768,
			32767, 1, -1, -1, 1, 0, 0, -1, -23456, 32767};
		logic signed [CW-1:0] dz [20] = '{0, 5, -32768, 32767, 0, 1000, -32768, 0, 0, -32768,
			32767, 0, 0, 0, 0, 32767, -32768, -1, 3456, 1};
		int i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (i = 0; i < 20; i++)
			send_vector(dx[i], dy[i], dz[i]);
		wait_results_drained();
	endtask

	// random vectors under one idling and stalling setting
	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		logic signed [CW-1:0] x, y, z;
		int n, mix;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++) begin
			mix = $urandom_range(9);
			if (mix < 5) begin
				x = pick_component(0);
				y = pick_component(0);
				z = pick_component(0);
			end else if (mix == 5) begin
				x = pick_component(1);
				y = pick_component(1);
				z = pick_component(1);
			end else if (mix == 6) begin
				x = pick_component(2);
				y = pick_component(2);
				z = pick_component(2);
			end else if (mix == 7) begin
				// on an axis, or with no horizontal part at all
				x = pick_component($urandom_range(1) ? 3 : 0);
				y = pick_component($urandom_range(1) ? 3 : 0);
				z = pick_component($urandom_range(2));
			end else begin
				x = pick_component($urandom_range(2));
				y = pick_component($urandom_range(2));
				z = pick_component(mix == 8 ? 3 : 1);
			end
			send_vector(x, y, z);
		end
		wait_results_drained();
	endtask

	// long receiver hold-off while vectors keep coming, so the pipeline fills and stalls
	task automatic test_backpressure();
		int n;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (n = 0; n < 120; n++)
			send_vector(pick_component(0), pick_component(0), pick_component(0));
		wait_results_drained();
	endtask

	// reset, then the tests in turn
	initial begin
		arst_n = 1'b0;
		vec.valid = 1'b0;
		vec.dir_x = '0;
		vec.dir_y = '0;
		vec.dir_z = '0;
		angles.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200, 0, 0);
		test_random(200, 83, 0);
		test_random(200, 0, 83);
		test_random(200, 35, 35);
		test_backpressure();

		repeat (LATENCY) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
